[rtl/tli_pkg.sv]
package tli_pkg;

  localparam int DefTapeDepth    = 32768;
  localparam int DefProgramDepth = 4096;
  localparam int DefStackDepth   = 64;

  localparam int ByteW = 8;
  localparam int PcOutW = 13;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_STEP = 1'b1;

  localparam logic [7:0] CH_OPEN   = 8'h5B;
  localparam logic [7:0] CH_CLOSE  = 8'h5D;
  localparam logic [7:0] CH_INC    = 8'h2B;
  localparam logic [7:0] CH_DEC    = 8'h2D;
  localparam logic [7:0] CH_LEFT   = 8'h3C;
  localparam logic [7:0] CH_RIGHT  = 8'h3E;
  localparam logic [7:0] CH_PUT    = 8'h2E;
  localparam logic [7:0] CH_GET    = 8'h2C;
  localparam logic [7:0] CH_REPORT = 8'h3F;

  localparam logic [1:0] KIND_NONE  = 2'd0;
  localparam logic [1:0] KIND_CHAR  = 2'd1;
  localparam logic [1:0] KIND_VALUE = 2'd2;

  localparam logic [1:0] FAULT_NONE     = 2'd0;
  localparam logic [1:0] FAULT_EMPTY    = 2'd1;
  localparam logic [1:0] FAULT_SKIP     = 2'd2;
  localparam logic [1:0] FAULT_OVERFLOW = 2'd3;

  typedef struct packed {
    logic latch;
    logic load;
    logic exec;
    logic skip_sel;
    logic skip_step;
    logic skip_fail;
    logic clear_step;
    logic out_load;
  } tli_cmd_t;

  typedef struct packed {
    logic       item_load;
    logic       runnable;
    logic       need_skip;
    logic       skip_end;
    logic       skip_found;
    logic       clr_last;
    logic [1:0] fault;
  } tli_sts_t;

endpackage

[rtl/tli_ctrl.sv]
module tli_ctrl
  import tli_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      s_tvalid,
  output logic      s_tready,
  output logic      m_tvalid,
  input  logic      m_tready,
  input  tli_sts_t  sts,
  output tli_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DISPATCH,
    S_SKIP_RD,
    S_SKIP_CHK,
    S_RESULT
  } state_t;

  state_t state;
  logic   slot_free;
  logic   accept;

  always_comb begin
    slot_free = !m_tvalid || m_tready;
    s_tready  = (state == S_IDLE) || ((state == S_RESULT) && slot_free);
    accept    = s_tvalid && s_tready;
    cmd       = '0;
    cmd.latch = accept;
    case (state)
      S_CLEAR: begin
        cmd.clear_step = 1'b1;
      end
      S_DISPATCH: begin
        cmd.load = sts.item_load;
        cmd.exec = !sts.item_load && sts.runnable;
      end
      S_SKIP_RD: begin
        cmd.skip_sel  = 1'b1;
        cmd.skip_fail = sts.skip_end;
      end
      S_SKIP_CHK: begin
        cmd.skip_step = 1'b1;
      end
      S_RESULT: begin
        cmd.out_load = slot_free;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      m_tvalid <= 1'b0;
    end else begin
      if (cmd.out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          if (sts.clr_last) state <= S_IDLE;
        end
        S_IDLE: begin
          if (accept) state <= S_DISPATCH;
        end
        S_DISPATCH: begin
          if (cmd.exec && sts.need_skip) state <= S_SKIP_RD;
          else state <= S_RESULT;
        end
        S_SKIP_RD: begin
          if (sts.skip_end) state <= S_RESULT;
          else state <= S_SKIP_CHK;
        end
        S_SKIP_CHK: begin
          if (sts.skip_found) state <= S_RESULT;
          else state <= S_SKIP_RD;
        end
        S_RESULT: begin
          if (slot_free) begin
            if (accept) state <= S_DISPATCH;
            else state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

[rtl/tli_dp.sv]
module tli_dp
  import tli_pkg::*;
#(
  parameter int TAPE_DEPTH    = DefTapeDepth,
  parameter int PROGRAM_DEPTH = DefProgramDepth,
  parameter int STACK_DEPTH   = DefStackDepth
) (
  input  logic        clk,
  input  logic        rst,
  input  logic [15:0] s_tdata,
  input  logic [1:0]  s_tuser,
  output logic [23:0] m_tdata,
  output logic [1:0]  m_tuser,
  input  tli_cmd_t    cmd,
  output tli_sts_t    sts
);

  localparam int PA = $clog2(PROGRAM_DEPTH);
  localparam int PW = $clog2(PROGRAM_DEPTH + 1);
  localparam int TW = $clog2(TAPE_DEPTH);
  localparam int SA = $clog2(STACK_DEPTH);
  localparam int DW = $clog2(STACK_DEPTH + 1);

  logic [ByteW-1:0] prog_mem [PROGRAM_DEPTH];
  logic [ByteW-1:0] tape_mem [TAPE_DEPTH];
  logic [PA-1:0]    stack_mem [STACK_DEPTH];

  logic             it_cmd;
  logic [ByteW-1:0] it_char;
  logic [ByteW-1:0] it_byte;
  logic             it_eof;

  logic [PW-1:0]    len;
  logic [PW-1:0]    pc;
  logic [TW-1:0]    tp;
  logic [DW-1:0]    depth;
  logic [1:0]       fault;
  logic [TW-1:0]    clr_addr;
  logic [PW-1:0]    skip_j;
  logic [PW-1:0]    nest;
  logic [1:0]       kind;
  logic [ByteW-1:0] kbyte;

  logic [ByteW-1:0] prog_q;
  logic [ByteW-1:0] tape_q;
  logic [PA-1:0]    stk_q;

  logic [PA-1:0]    prog_raddr;
  logic [SA-1:0]    stk_raddr;

  logic [PW-1:0]    pc_next;
  logic [TW-1:0]    tp_next;
  logic [DW-1:0]    depth_next;
  logic [1:0]       fault_next;
  logic [1:0]       kind_next;
  logic [ByteW-1:0] kbyte_next;
  logic             tape_we;
  logic [ByteW-1:0] tape_wd;
  logic             push;
  logic             skip_go;

  always_comb begin
    prog_raddr = cmd.skip_sel ? skip_j[PA-1:0] : pc[PA-1:0];
    stk_raddr  = (depth == '0) ? '0 : SA'(depth - DW'(1));
  end

  always_ff @(posedge clk) begin
    prog_q <= prog_mem[prog_raddr];
    if (cmd.load && (len < PW'(PROGRAM_DEPTH))) begin
      prog_mem[len[PA-1:0]] <= it_char;
    end
  end

  always_ff @(posedge clk) begin
    tape_q <= tape_mem[tp];
    if (cmd.clear_step) begin
      tape_mem[clr_addr] <= '0;
    end else if (cmd.exec && tape_we) begin
      tape_mem[tp] <= tape_wd;
    end
  end

  always_ff @(posedge clk) begin
    stk_q <= stack_mem[stk_raddr];
    if (cmd.exec && push) begin
      stack_mem[depth[SA-1:0]] <= pc[PA-1:0];
    end
  end

  always_comb begin
    pc_next    = pc + PW'(1);
    tp_next    = tp;
    depth_next = depth;
    fault_next = fault;
    kind_next  = KIND_NONE;
    kbyte_next = '0;
    tape_we    = 1'b0;
    tape_wd    = tape_q;
    push       = 1'b0;
    skip_go    = 1'b0;
    case (prog_q)
      CH_INC: begin
        tape_we = 1'b1;
        tape_wd = tape_q + ByteW'(1);
      end
      CH_DEC: begin
        tape_we = 1'b1;
        tape_wd = tape_q - ByteW'(1);
      end
      CH_RIGHT: begin
        tp_next = (tp == TW'(TAPE_DEPTH - 1)) ? '0 : tp + TW'(1);
      end
      CH_LEFT: begin
        tp_next = (tp == '0) ? TW'(TAPE_DEPTH - 1) : tp - TW'(1);
      end
      CH_GET: begin
        tape_we = 1'b1;
        tape_wd = it_eof ? '1 : it_byte;
      end
      CH_PUT: begin
        kind_next  = KIND_CHAR;
        kbyte_next = tape_q;
      end
      CH_REPORT: begin
        kind_next  = KIND_VALUE;
        kbyte_next = tape_q;
      end
      CH_OPEN: begin
        if (tape_q != '0) begin
          if (depth == DW'(STACK_DEPTH)) begin
            fault_next = FAULT_OVERFLOW;
            pc_next    = pc;
          end else begin
            push       = 1'b1;
            depth_next = depth + DW'(1);
          end
        end else begin
          skip_go = 1'b1;
          pc_next = pc;
        end
      end
      CH_CLOSE: begin
        if (depth == '0) begin
          fault_next = FAULT_EMPTY;
          pc_next    = pc;
        end else if (tape_q != '0) begin
          pc_next = PW'(stk_q) + PW'(1);
        end else begin
          depth_next = depth - DW'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      it_cmd  <= s_tuser[0];
      it_eof  <= s_tuser[1];
      it_char <= s_tdata[7:0];
      it_byte <= s_tdata[15:8];
      kind    <= KIND_NONE;
      kbyte   <= '0;
    end
    if (cmd.exec) begin
      kind  <= kind_next;
      kbyte <= kbyte_next;
      if (skip_go) begin
        skip_j <= pc + PW'(1);
        nest   <= '0;
      end
    end
    if (cmd.skip_step && !sts.skip_found) begin
      skip_j <= skip_j + PW'(1);
      if (prog_q == CH_OPEN) nest <= nest + PW'(1);
      else if (prog_q == CH_CLOSE) nest <= nest - PW'(1);
    end
    if (cmd.out_load) begin
      m_tuser        <= kind;
      m_tdata[7:0]   <= kbyte;
      m_tdata[8]     <= (pc >= len);
      m_tdata[10:9]  <= fault;
      m_tdata[23:11] <= PcOutW'(pc);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      len      <= '0;
      pc       <= '0;
      tp       <= '0;
      depth    <= '0;
      fault    <= FAULT_NONE;
      clr_addr <= '0;
    end else begin
      if (cmd.clear_step) clr_addr <= clr_addr + TW'(1);
      if (cmd.load && (len < PW'(PROGRAM_DEPTH))) len <= len + PW'(1);
      if (cmd.exec) begin
        pc    <= pc_next;
        tp    <= tp_next;
        depth <= depth_next;
        fault <= fault_next;
      end
      if (cmd.skip_fail) fault <= FAULT_SKIP;
      if (cmd.skip_step && sts.skip_found) pc <= skip_j + PW'(1);
    end
  end

  always_comb begin
    sts.item_load  = (it_cmd == CMD_LOAD);
    sts.runnable   = (fault == FAULT_NONE) && (pc < len);
    sts.need_skip  = (prog_q == CH_OPEN) && (tape_q == '0);
    sts.skip_end   = (skip_j >= len);
    sts.skip_found = (prog_q == CH_CLOSE) && (nest == '0);
    sts.clr_last   = (clr_addr == TW'(TAPE_DEPTH - 1));
    sts.fault      = fault;
  end

endmodule

[rtl/tape_language_interpreter_core.sv]
// channel  direction  payload
// s_*      in         tuser: cmd, input_eof; tdata: program_char, input_byte
// m_*      out        tuser: out_kind; tdata: out_byte, halted, error_code, program_counter
//
// a load item or a plain step runs through dispatch and result, the next item entering as the result leaves
// a forward skip over a zero cell walks the program characters after it,
// one program memory read and one compare each, and one more read when no match turns up
// after reset the tape is cleared one cell at a time, with s_tready low
// a result waits in the output register while m_tready is low; one more item is still taken, then input is held off
module tape_language_interpreter_core
  import tli_pkg::*;
#(
  parameter int TAPE_DEPTH    = DefTapeDepth,
  parameter int PROGRAM_DEPTH = DefProgramDepth,
  parameter int STACK_DEPTH   = DefStackDepth
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,  // program_char, input_byte
  input  logic [1:0]  s_tuser,  // cmd, input_eof
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,  // out_byte, halted, error_code, program_counter
  output logic [1:0]  m_tuser   // out_kind
);

  tli_cmd_t cmd;
  tli_sts_t sts;

  tli_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  tli_dp #(
    .TAPE_DEPTH    (TAPE_DEPTH),
    .PROGRAM_DEPTH (PROGRAM_DEPTH),
    .STACK_DEPTH   (STACK_DEPTH)
  ) u_dp (
    .clk     (clk),
    .rst     (rst),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser),
    .cmd     (cmd),
    .sts     (sts)
  );

`ifndef SYNTHESIS
  a_fault_sticky: assert property (@(posedge clk) disable iff (rst)
    (sts.fault != FAULT_NONE) |=> (sts.fault == $past(sts.fault)))
    else $error("fault changed after being set");

  a_no_accept_clear: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> !cmd.clear_step)
    else $error("item accepted during tape clear");

  a_kind_clean: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tuser != KIND_NONE)) |-> ((m_tdata[10:9] == FAULT_NONE) &&
      (m_tuser != 2'd3)))
    else $error("output item reported with fault or bad kind");
`endif

endmodule

[dv/tb_tape_language_interpreter_core.sv]
module tb_tape_language_interpreter_core;
  timeunit 1ns;
  timeprecision 1ps;

  import tli_pkg::*;

  localparam int TAPE_N = DefTapeDepth;
  localparam int PROG_N = 1024;
  localparam int STACK_N = DefStackDepth;
  localparam int ITEM_GOAL = 1550;
  localparam int HOLD_CYCLES = 400;
  localparam int SCRIPT_N = 30;
  localparam longint CYCLE_LIMIT = 4_000_000;

  // laid out so that {m_tuser, m_tdata} maps onto it directly
  typedef struct packed {
    logic [1:0]  kind;
    logic [12:0] pc;
    logic [1:0]  err;
    logic        halted;
    logic [7:0]  value;
  } report_t;

  typedef struct packed {
    logic       cmd;
    logic [7:0] pchar;
    logic [7:0] ibyte;
    logic       eof;
    logic       typed;
    report_t    want;
  } script_row_t;

  localparam report_t NO_REPORT = '0;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;
  logic [1:0]  m_tuser;

  // shadow machine state
  logic [7:0] prog_mem [PROG_N];
  int         prog_len = 0;
  logic [7:0] tape_mem [TAPE_N];
  int         tape_ptr = 0;
  int         pc_now = 0;
  int         loop_ret [STACK_N];
  int         loop_depth = 0;
  logic [1:0] fault_code = FAULT_NONE;

  report_t    pending_reports [$];
  logic [7:0] snippet [$];

  int     items_sent = 0;
  int     loads_sent = 0;
  int     steps_sent = 0;
  int     checked = 0;
  int     outputs_seen = 0;
  int     mismatches = 0;
  bit     tx_calm = 1'b0;
  bit     hold_done = 1'b0;
  longint cycles = 0;

  script_row_t script [SCRIPT_N] = '{
    '{CMD_STEP, 8'h00, 8'h5A, 1'b0, 1'b1, '{KIND_NONE, 13'd0, FAULT_NONE, 1'b1, 8'h00}},
    '{CMD_LOAD, CH_GET,    8'hFF, 1'b1, 1'b0, NO_REPORT},
    '{CMD_LOAD, CH_REPORT, 8'h00, 1'b0, 1'b0, NO_REPORT},
    '{CMD_LOAD, CH_GET,    8'hFF, 1'b1, 1'b0, NO_REPORT},
    '{CMD_LOAD, CH_REPORT, 8'h00, 1'b0, 1'b0, NO_REPORT},
    '{CMD_LOAD, CH_DEC,    8'hFF, 1'b1, 1'b0, NO_REPORT},
    '{CMD_LOAD, CH_REPORT, 8'h00, 1'b0, 1'b0, NO_REPORT},
    '{CMD_LOAD, CH_LEFT,   8'hFF, 1'b1, 1'b0, NO_REPORT},
    '{CMD_LOAD, CH_REPORT, 8'h00, 1'b0, 1'b0, NO_REPORT},
    '{CMD_LOAD, CH_RIGHT,  8'hFF, 1'b1, 1'b0, NO_REPORT},
    '{CMD_LOAD, CH_PUT,    8'h00, 1'b0, 1'b0, NO_REPORT},
    '{CMD_LOAD, 8'h00,     8'hFF, 1'b1, 1'b0, NO_REPORT},
    '{CMD_LOAD, 8'hFF,     8'h00, 1'b0, 1'b0, NO_REPORT},
    '{CMD_LOAD, CH_INC,    8'hFF, 1'b1, 1'b0, NO_REPORT},
    '{CMD_LOAD, CH_PUT,    8'h00, 1'b0, 1'b0, NO_REPORT},
    '{CMD_STEP, 8'hFF, 8'hA5, 1'b0, 1'b0, NO_REPORT},
    '{CMD_STEP, 8'h00, 8'h5A, 1'b0, 1'b1, '{KIND_VALUE, 13'd2, FAULT_NONE, 1'b0, 8'hA5}},
    '{CMD_STEP, 8'hFF, 8'h00, 1'b1, 1'b0, NO_REPORT},
    '{CMD_STEP, 8'h00, 8'h5A, 1'b0, 1'b1, '{KIND_VALUE, 13'd4, FAULT_NONE, 1'b0, 8'hFF}},
    '{CMD_STEP, 8'hFF, 8'hA5, 1'b1, 1'b0, NO_REPORT},
    '{CMD_STEP, 8'h00, 8'h5A, 1'b0, 1'b1, '{KIND_VALUE, 13'd6, FAULT_NONE, 1'b0, 8'hFE}},
    '{CMD_STEP, 8'hFF, 8'hA5, 1'b1, 1'b0, NO_REPORT},
    '{CMD_STEP, 8'h00, 8'h5A, 1'b0, 1'b1, '{KIND_VALUE, 13'd8, FAULT_NONE, 1'b0, 8'h00}},
    '{CMD_STEP, 8'hFF, 8'hA5, 1'b1, 1'b0, NO_REPORT},
    '{CMD_STEP, 8'h00, 8'h5A, 1'b0, 1'b1, '{KIND_CHAR, 13'd10, FAULT_NONE, 1'b0, 8'hFE}},
    '{CMD_STEP, 8'hFF, 8'hA5, 1'b1, 1'b0, NO_REPORT},
    '{CMD_STEP, 8'h00, 8'h5A, 1'b0, 1'b0, NO_REPORT},
    '{CMD_STEP, 8'hFF, 8'hA5, 1'b1, 1'b0, NO_REPORT},
    '{CMD_STEP, 8'h00, 8'h5A, 1'b0, 1'b1, '{KIND_CHAR, 13'd14, FAULT_NONE, 1'b1, 8'hFF}},
    '{CMD_STEP, 8'hFF, 8'hA5, 1'b1, 1'b1, '{KIND_NONE, 13'd14, FAULT_NONE, 1'b1, 8'h00}}
  };

  tape_language_interpreter_core #(
    .PROGRAM_DEPTH (PROG_N)
  ) DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tape_language_interpreter_core: mismatch");
      $finish;
    end
  end

  function automatic report_t interpret(input logic cmd, input logic [7:0] pchar,
                                        input logic [7:0] ibyte, input logic eof);
    report_t    r;
    logic [7:0] op;
    logic [7:0] cellv;
    int         j;
    int         nest;
    bit         found;
    bit         advance;
    r = '0;
    if (cmd == CMD_LOAD) begin
      if (prog_len < PROG_N) begin
        prog_mem[prog_len] = pchar;
        prog_len++;
      end
    end else if (fault_code == FAULT_NONE && pc_now < prog_len) begin
      op = prog_mem[pc_now];
      cellv = tape_mem[tape_ptr];
      advance = 1'b1;
      case (op)
        CH_INC: tape_mem[tape_ptr] = cellv + 8'd1;
        CH_DEC: tape_mem[tape_ptr] = cellv - 8'd1;
        CH_RIGHT: tape_ptr = (tape_ptr == TAPE_N - 1) ? 0 : tape_ptr + 1;
        CH_LEFT: tape_ptr = (tape_ptr == 0) ? TAPE_N - 1 : tape_ptr - 1;
        CH_GET: tape_mem[tape_ptr] = eof ? 8'hFF : ibyte;
        CH_PUT: begin
          r.kind = KIND_CHAR;
          r.value = cellv;
        end
        CH_REPORT: begin
          r.kind = KIND_VALUE;
          r.value = cellv;
        end
        CH_OPEN: begin
          if (cellv != 8'd0) begin
            if (loop_depth >= STACK_N) begin
              fault_code = FAULT_OVERFLOW;
              advance = 1'b0;
            end else begin
              loop_ret[loop_depth] = pc_now;
              loop_depth++;
            end
          end else begin
            // walk forward to the matching close
            j = pc_now + 1;
            nest = 0;
            found = 1'b0;
            while (!found && j < prog_len) begin
              if (prog_mem[j] == CH_OPEN) begin
                nest++;
              end else if (prog_mem[j] == CH_CLOSE) begin
                if (nest == 0) found = 1'b1;
                else nest--;
              end
              if (!found) j++;
            end
            advance = 1'b0;
            if (found) pc_now = j + 1;
            else fault_code = FAULT_SKIP;
          end
        end
        CH_CLOSE: begin
          if (loop_depth == 0) begin
            fault_code = FAULT_EMPTY;
            advance = 1'b0;
          end else if (cellv != 8'd0) begin
            pc_now = loop_ret[loop_depth - 1] + 1;
            advance = 1'b0;
          end else begin
            loop_depth--;
          end
        end
        default: ;
      endcase
      if (advance) pc_now++;
    end
    r.halted = (pc_now >= prog_len);
    r.err = fault_code;
    r.pc = pc_now[12:0];
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] plain_op(input bit moves);
    logic [7:0] c;
    case ($urandom_range(0, 9))
      0, 1: c = CH_INC;
      2: c = CH_DEC;
      3: c = CH_GET;
      4: c = CH_PUT;
      5: c = CH_REPORT;
      6: c = CH_LEFT;
      7: c = CH_RIGHT;
      default: begin
        do c = 8'($urandom_range(0, 255));
        while (c inside {CH_OPEN, CH_CLOSE, CH_LEFT, CH_RIGHT});
      end
    endcase
    if (!moves && (c == CH_LEFT || c == CH_RIGHT)) c = CH_DEC;
    return c;
  endfunction

  // clear the cell, count it up a little, loop on it with the body one cell to the right
  task automatic gen_loop(input int depth);
    snippet.push_back(CH_OPEN);
    snippet.push_back(CH_DEC);
    snippet.push_back(CH_CLOSE);
    repeat ($urandom_range(0, 3)) snippet.push_back(CH_INC);
    snippet.push_back(CH_OPEN);
    snippet.push_back(CH_RIGHT);
    repeat ($urandom_range(0, 4)) snippet.push_back(plain_op(1'b0));
    if (depth > 0 && $urandom_range(0, 1) == 1) gen_loop(depth - 1);
    repeat ($urandom_range(0, 2)) snippet.push_back(plain_op(1'b0));
    snippet.push_back(CH_LEFT);
    snippet.push_back(CH_DEC);
    snippet.push_back(CH_CLOSE);
  endtask

  // entered and left at a falling edge
  task automatic send_item(input logic cmd, input logic [7:0] pchar, input logic [7:0] ibyte,
                           input logic eof, input logic typed, input report_t want);
    int      gap;
    report_t predicted;
    gap = tx_calm ? 0 : pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {ibyte, pchar};
    s_tuser <= {eof, cmd};
    do @(posedge clk); while (!s_tready);
    predicted = interpret(cmd, pchar, ibyte, eof);
    pending_reports.push_back(typed ? want : predicted);
    items_sent++;
    if (cmd == CMD_LOAD) loads_sent++;
    else steps_sent++;
    if (items_sent % 64 == 0 && $urandom_range(0, 2) == 0) tx_calm = !tx_calm;
    @(negedge clk);
  endtask

  task automatic step_random();
    logic [7:0] ibyte;
    ibyte = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                        : 8'($urandom_range(0, 4));
    send_item(CMD_STEP, 8'($urandom_range(0, 255)), ibyte, $urandom_range(0, 7) == 0,
              1'b0, NO_REPORT);
  endtask

  task automatic load_char(input logic [7:0] c);
    send_item(CMD_LOAD, c, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
              1'b0, NO_REPORT);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    @(negedge clk);
    while (pending_reports.size() != 0) @(negedge clk);
  endtask

  always @(posedge clk) begin
    report_t got;
    report_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = {m_tuser, m_tdata};
      if (pending_reports.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("result with nothing expected: %h", got);
      end else begin
        want = pending_reports.pop_front();
        checked++;
        if (got.kind != KIND_NONE) outputs_seen++;
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("result %0d (expected/actual): kind %0d/%0d byte %h/%h halted %b/%b",
                     checked, want.kind, got.kind, want.value, got.value, want.halted,
                     got.halted);
            $display("  error %0d/%0d pc %0d/%0d", want.err, got.err, want.pc, got.pc);
          end
        end
      end
    end
  end

  initial begin
    int rx_wait;
    int rx_cycles;
    bit rx_calm;
    rx_wait = 0;
    rx_cycles = 0;
    rx_calm = 1'b0;
    forever begin
      @(negedge clk);
      rx_cycles++;
      if (rx_cycles % 256 == 0 && $urandom_range(0, 2) == 0) rx_calm = !rx_calm;
      // one long back-pressure stretch so the core fills up and stalls its input
      if (!hold_done && checked >= 300) begin
        hold_done = 1'b1;
        rx_wait = HOLD_CYCLES;
      end
      if (rx_wait > 0) begin
        m_tready <= 1'b0;
        rx_wait--;
      end else begin
        m_tready <= 1'b1;
        if (!rx_calm && $urandom_range(0, 3) == 0) rx_wait = pick_gap();
      end
    end
  end

  initial begin
    logic [1:0] fault_pick;
    foreach (tape_mem[i]) tape_mem[i] = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (script[i]) begin
      send_item(script[i].cmd, script[i].pchar, script[i].ibyte, script[i].eof,
                script[i].typed, script[i].want);
    end
    drain();

    // balanced programs appended in chunks, each run until the counter reaches the end;
    // the loads that later fill the store count against the item budget
    while (items_sent + (PROG_N - prog_len) < ITEM_GOAL && prog_len < PROG_N - 200) begin
      snippet.delete();
      repeat ($urandom_range(1, 4)) begin
        if ($urandom_range(0, 2) == 0) begin
          repeat ($urandom_range(1, 6)) snippet.push_back(plain_op(1'b1));
        end else begin
          gen_loop($urandom_range(0, 2));
        end
      end
      repeat ($urandom_range(0, 2)) step_random();
      foreach (snippet[i]) load_char(snippet[i]);
      while (pc_now < prog_len) step_random();
      if ($urandom_range(0, 7) == 0) drain();
    end

    // faults are sticky, so one kind closes the run
    fault_pick = 2'($urandom_range(1, 3));
    snippet.delete();
    case (fault_pick)
      FAULT_EMPTY: begin
        if ($urandom_range(0, 1) == 1) snippet.push_back(CH_INC);
        snippet.push_back(CH_CLOSE);
      end
      FAULT_SKIP: begin
        snippet = '{CH_OPEN, CH_DEC, CH_CLOSE, CH_OPEN, CH_OPEN, CH_INC, CH_CLOSE, CH_PUT};
      end
      default: begin
        snippet = '{CH_OPEN, CH_DEC, CH_CLOSE, CH_INC};
        repeat (STACK_N + 1) snippet.push_back(CH_OPEN);
      end
    endcase
    foreach (snippet[i]) load_char(snippet[i]);
    while (fault_code == FAULT_NONE) step_random();
    repeat (3) step_random();

    // loads still land after a fault, until the store is full
    while (prog_len < PROG_N) load_char(8'($urandom_range(0, 255)));
    repeat (3) load_char(8'($urandom_range(0, 255)));
    step_random();
    drain();
    repeat (8) @(posedge clk);

    $display("%0d load and %0d step items, %0d results checked, %0d carried a cell byte",
             loads_sent, steps_sent, checked, outputs_seen);
    $display("program store filled to %0d characters, run closed on fault code %0d",
             prog_len, fault_code);
    if (mismatches == 0) begin
      $display("tape_language_interpreter_core: match");
    end else begin
      $display("tape_language_interpreter_core: mismatch");
    end
    $finish;
  end

endmodule
